[hw/rtl/prf_pkg.sv]
package prf_pkg;

  localparam logic [7:0] BCAST_ADDR = 8'hFF;

  localparam logic [2:0] KIND_UNREL = 3'd0;
  localparam logic [2:0] KIND_REL   = 3'd1;
  localparam logic [2:0] KIND_ACK   = 3'd2;
  localparam logic [2:0] KIND_NACK  = 3'd3;

  localparam logic [2:0] ST_ACCEPTED  = 3'd0;
  localparam logic [2:0] ST_OWN_ECHO  = 3'd1;
  localparam logic [2:0] ST_NOT_ADDR  = 3'd2;
  localparam logic [2:0] ST_DUPLICATE = 3'd3;
  localparam logic [2:0] ST_UNKNOWN   = 3'd4;

  localparam logic [7:0] REG_MY_ADDRESS      = 8'd0;
  localparam logic [7:0] REG_REPEATER_ENABLE = 8'd1;
  localparam logic [7:0] REG_SEEN_EXPIRY     = 8'd2;
  localparam logic [7:0] REG_DLV_EXPIRY      = 8'd3;

  localparam logic [31:0] EXPIRY_RESET = 32'd30000;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [7:0]  src_addr;
    logic [7:0]  dest_addr;
    logic [2:0]  packet_kind;
    logic [7:0]  sequence_req;
    logic [7:0]  hop_ttl;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       deliver;
    logic       send_ack;
    logic       clear_pending;
    logic [7:0] reply_addr;
    logic [7:0] reply_sequence;
    logic       forward;
    logic [7:0] forward_ttl;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  my_address;
    logic        repeater_enable;
    logic [31:0] seen_expiry_ms;
    logic [31:0] delivered_expiry_ms;
  } cfg_regs_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [7:0]  src_addr;
    logic [7:0]  sequence_req;
    logic [7:0]  hop_ttl;
    logic [2:0]  packet_kind;
    logic        dst_bcast;
    logic        own_echo;
    logic        fwd_try;
    logic        addressed;
  } q_entry_t;

  typedef struct packed {
    logic [7:0]  src;
    logic [7:0]  seq;
    logic [31:0] stamp;
  } ring_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_LAST,
    BK_COMMIT
  } back_state_t;

endpackage

[hw/rtl/prf_in_if.sv]
interface prf_in_if;
  import prf_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/prf_out_if.sv]
interface prf_out_if;
  import prf_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/prf_cfg_if.sv]
interface prf_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

[hw/rtl/prf_ram.sv]
module prf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/prf_front.sv]
module prf_front (
  prf_in_if.sink             in_chan,
  input  prf_pkg::cfg_regs_t cfg,
  input  logic               q_full,
  output logic               push,
  output prf_pkg::q_entry_t  push_data
);
  import prf_pkg::*;

  logic own_echo;

  assign in_chan.ready = !q_full;
  assign push          = in_chan.valid && !q_full;
  assign own_echo      = (in_chan.data.src_addr == cfg.my_address);

  always_comb begin
    push_data.now_ms       = in_chan.data.now_ms;
    push_data.src_addr     = in_chan.data.src_addr;
    push_data.sequence_req = in_chan.data.sequence_req;
    push_data.hop_ttl      = in_chan.data.hop_ttl;
    push_data.packet_kind  = in_chan.data.packet_kind;
    push_data.dst_bcast    = (in_chan.data.dest_addr == BCAST_ADDR);
    push_data.own_echo     = own_echo;
    push_data.fwd_try      = !own_echo && cfg.repeater_enable
                             && (in_chan.data.hop_ttl != 8'd0);
    push_data.addressed    = (in_chan.data.dest_addr == cfg.my_address)
                             || (in_chan.data.dest_addr == BCAST_ADDR);
  end

endmodule

[hw/rtl/prf_queue.sv]
module prf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  prf_pkg::q_entry_t push_data,
  output logic              full,
  output logic              q_valid,
  output prf_pkg::q_entry_t q_data,
  input  logic              pop
);
  import prf_pkg::*;

  q_entry_t   slot_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hw/rtl/prf_back.sv]
module prf_back #(
  parameter int SEEN_ENTRIES      = 16,
  parameter int DELIVERED_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  prf_pkg::cfg_regs_t cfg,
  input  logic               q_valid,
  input  prf_pkg::q_entry_t  q_data,
  output logic               q_pop,
  prf_out_if.source          out_chan
);
  import prf_pkg::*;

  localparam int SEEN_AW = $clog2(SEEN_ENTRIES);
  localparam int DLV_AW  = $clog2(DELIVERED_ENTRIES);
  localparam int SCAN_N  = (SEEN_ENTRIES > DELIVERED_ENTRIES) ? SEEN_ENTRIES
                                                              : DELIVERED_ENTRIES;
  localparam int CNT_W   = $clog2(SCAN_N);

  back_state_t state_r;
  back_state_t state_nxt;

  logic [CNT_W-1:0] scan_cnt_r;
  logic [CNT_W-1:0] scan_cnt_nxt;
  logic             rd_en_r;
  logic [CNT_W-1:0] rd_idx_r;
  q_entry_t         work_r;
  logic             seen_hit_r;
  logic             dlv_hit_r;
  logic [SEEN_AW-1:0] seen_head_r;
  logic [DLV_AW-1:0]  dlv_head_r;
  logic [SEEN_ENTRIES-1:0]      seen_vld_r;
  logic [DELIVERED_ENTRIES-1:0] dlv_vld_r;
  logic      out_vld_r;
  out_item_t out_data_r;

  logic        proceed;
  logic        seen_we;
  logic        dlv_we;
  logic        dlv_new;
  ring_entry_t wr_entry;
  ring_entry_t seen_rd;
  ring_entry_t dlv_rd;
  logic [SEEN_AW-1:0] seen_idx;
  logic [DLV_AW-1:0]  dlv_idx;
  logic [31:0] seen_age;
  logic [31:0] dlv_age;
  logic        seen_match;
  logic        dlv_match;
  out_item_t   res;

  assign wr_entry = '{src: work_r.src_addr, seq: work_r.sequence_req, stamp: work_r.now_ms};

  prf_ram #(.WIDTH($bits(ring_entry_t)), .DEPTH(SEEN_ENTRIES)) u_seen_ram (
    .clk   (clk),
    .we    (seen_we),
    .waddr (seen_head_r),
    .wdata (wr_entry),
    .raddr (scan_cnt_r[SEEN_AW-1:0]),
    .rdata (seen_rd)
  );

  prf_ram #(.WIDTH($bits(ring_entry_t)), .DEPTH(DELIVERED_ENTRIES)) u_dlv_ram (
    .clk   (clk),
    .we    (dlv_we),
    .waddr (dlv_head_r),
    .wdata (wr_entry),
    .raddr (scan_cnt_r[DLV_AW-1:0]),
    .rdata (dlv_rd)
  );

  // compare one entry of each ring per cycle
  always_comb begin
    seen_idx   = rd_idx_r[SEEN_AW-1:0];
    dlv_idx    = rd_idx_r[DLV_AW-1:0];
    seen_age   = work_r.now_ms - seen_rd.stamp;
    dlv_age    = work_r.now_ms - dlv_rd.stamp;
    seen_match = rd_en_r && (rd_idx_r <= CNT_W'(SEEN_ENTRIES - 1))
                 && seen_vld_r[seen_idx]
                 && (seen_rd.src == work_r.src_addr)
                 && (seen_rd.seq == work_r.sequence_req)
                 && (seen_age < cfg.seen_expiry_ms);
    dlv_match  = rd_en_r && (rd_idx_r <= CNT_W'(DELIVERED_ENTRIES - 1))
                 && dlv_vld_r[dlv_idx]
                 && (dlv_rd.src == work_r.src_addr)
                 && (dlv_rd.seq == work_r.sequence_req)
                 && (dlv_age < cfg.delivered_expiry_ms);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:   if (q_valid) state_nxt = BK_SCAN;
      BK_SCAN:   if (scan_cnt_r == CNT_W'(SCAN_N - 1)) state_nxt = BK_LAST;
      BK_LAST:   state_nxt = BK_COMMIT;
      BK_COMMIT: if (!out_vld_r || out_chan.ready) state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop        = 1'b0;
    proceed      = 1'b0;
    scan_cnt_nxt = '0;
    unique case (state_r)
      BK_IDLE:   q_pop = q_valid;
      BK_SCAN:   scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
      BK_LAST:   q_pop = 1'b0;
      BK_COMMIT: proceed = !out_vld_r || out_chan.ready;
      default:   q_pop = 1'b0;
    endcase
  end

  always_comb begin
    dlv_new = !work_r.own_echo && work_r.addressed
              && (work_r.packet_kind == KIND_REL) && !dlv_hit_r;
    seen_we = proceed && work_r.fwd_try && !seen_hit_r;
    dlv_we  = proceed && dlv_new;
  end

  always_comb begin
    res                = '0;
    res.reply_addr     = work_r.src_addr;
    res.reply_sequence = work_r.sequence_req;
    res.forward        = work_r.fwd_try && !seen_hit_r;
    res.forward_ttl    = res.forward ? (work_r.hop_ttl - 8'd1) : 8'd0;
    priority if (work_r.own_echo) begin
      res.status = ST_OWN_ECHO;
    end else if (!work_r.addressed) begin
      res.status = ST_NOT_ADDR;
    end else if (work_r.packet_kind == KIND_UNREL) begin
      res.deliver = 1'b1;
    end else if (work_r.packet_kind == KIND_REL) begin
      if (dlv_hit_r) begin
        res.status   = ST_DUPLICATE;
        res.send_ack = 1'b1;
      end else begin
        res.deliver  = 1'b1;
        res.send_ack = !work_r.dst_bcast;
      end
    end else if (work_r.packet_kind == KIND_ACK || work_r.packet_kind == KIND_NACK) begin
      res.clear_pending = 1'b1;
    end else begin
      res.status = ST_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      scan_cnt_r  <= '0;
      rd_en_r     <= 1'b0;
      seen_hit_r  <= 1'b0;
      dlv_hit_r   <= 1'b0;
      seen_head_r <= '0;
      dlv_head_r  <= '0;
      seen_vld_r  <= '0;
      dlv_vld_r   <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      rd_en_r    <= (state_r == BK_SCAN);
      if (q_pop) begin
        seen_hit_r <= 1'b0;
        dlv_hit_r  <= 1'b0;
      end else begin
        seen_hit_r <= seen_hit_r || seen_match;
        dlv_hit_r  <= dlv_hit_r || dlv_match;
      end
      if (seen_we) begin
        seen_vld_r[seen_head_r] <= 1'b1;
        seen_head_r <= (seen_head_r == SEEN_AW'(SEEN_ENTRIES - 1)) ? '0
                       : seen_head_r + SEEN_AW'(1);
      end
      if (dlv_we) begin
        dlv_vld_r[dlv_head_r] <= 1'b1;
        dlv_head_r <= (dlv_head_r == DLV_AW'(DELIVERED_ENTRIES - 1)) ? '0
                      : dlv_head_r + DLV_AW'(1);
      end
      if (proceed) begin
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= scan_cnt_r;
    if (q_pop) begin
      work_r <= q_data;
    end
    if (proceed) begin
      out_data_r <= res;
    end
  end

  assign out_chan.valid = out_vld_r;
  assign out_chan.data  = out_data_r;

endmodule

[hw/rtl/packet_receive_filter_repeater_core.sv]
// receive filter and flooding repeater for decoded packet headers
//
// in_chan takes one header item (time stamp, addresses, kind, sequence, ttl);
// out_chan gives exactly one result item per header: status, deliver / ack /
// clear-pending requests, reply fields and the forward decision with its ttl.
// cfg_chan writes the four registers by index and is always ready; write it
// only while no header is in flight.
//
// back end: both rings sit in single-read-port RAMs and are scanned one entry per
// cycle over the larger of SEEN_ENTRIES and DELIVERED_ENTRIES; then the rings and
// the result register are updated in a commit state, which waits while the result
// register still holds an item the receiver has not taken. the back end takes a
// new header only after it has committed the last one.
//
// a two-entry queue sits between the classifier and the ring engine, so up to
// three more headers are taken while a result waits for the receiver: one held
// by the ring engine and two in the queue. a stalled receiver holds the result,
// then the queue fills and in_chan.ready drops.
// reset clears the registers to their defaults, empties the queue and clears
// all ring valid bits at once; no clearing pass is needed.
module packet_receive_filter_repeater_core #(
  parameter int SEEN_ENTRIES      = 16,
  parameter int DELIVERED_ENTRIES = 16
) (
  input logic       clk,
  input logic       rst_n,
  prf_in_if.sink    in_chan,
  prf_out_if.source out_chan,
  prf_cfg_if.sink   cfg_chan
);
  import prf_pkg::*;

  cfg_regs_t cfg_r;
  cfg_regs_t cfg_nxt;
  logic      push;
  q_entry_t  push_data;
  logic      q_full;
  logic      q_valid;
  q_entry_t  q_data;
  logic      q_pop;

  assign cfg_chan.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_MY_ADDRESS:      cfg_nxt.my_address          = cfg_chan.wdata[7:0];
        REG_REPEATER_ENABLE: cfg_nxt.repeater_enable     = cfg_chan.wdata[0];
        REG_SEEN_EXPIRY:     cfg_nxt.seen_expiry_ms      = cfg_chan.wdata;
        REG_DLV_EXPIRY:      cfg_nxt.delivered_expiry_ms = cfg_chan.wdata;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.my_address          <= 8'd0;
      cfg_r.repeater_enable     <= 1'b0;
      cfg_r.seen_expiry_ms      <= EXPIRY_RESET;
      cfg_r.delivered_expiry_ms <= EXPIRY_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  prf_front u_front (
    .in_chan   (in_chan),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  prf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (q_pop)
  );

  prf_back #(
    .SEEN_ENTRIES      (SEEN_ENTRIES),
    .DELIVERED_ENTRIES (DELIVERED_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

  // back end never takes two items in a row
  a_pop_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !q_pop)
    else $error("queue popped in consecutive cycles");

  // a forwarded copy never has a wrapped ttl
  a_fwd_ttl: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.data.forward |-> out_chan.data.forward_ttl != 8'hFF)
    else $error("forward with wrapped ttl");

  // own echoes cause no action at all
  a_echo_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.data.status == ST_OWN_ECHO) |->
      !out_chan.data.deliver && !out_chan.data.send_ack
      && !out_chan.data.clear_pending && !out_chan.data.forward)
    else $error("own echo produced an action");

  // a pop only happens with an item queued
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule
